// ----- src/bwwu_pkg.sv -----
// Shared types, constants and the count table builder for the bounded-weight word unranker.
package bwwu_pkg;

  localparam int MAX_BITS_DEF = 32;
  localparam int MAX_BITS_LIMIT = 32;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ONES = 2'd1;

  localparam logic [CFG_W-1:0] WORD_BITS_RST = 6'd32;
  localparam logic [CFG_W-1:0] MAX_ONES_RST = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Status of the shared compare and subtract unit.
  typedef struct packed {
    logic gt;
    logic a_zero;
  } cmp_sts_t;

  // Number of i-bit words with at most j ones, built from Pascal's triangle.
  function automatic logic [63:0] bounded_count(input int i, input int j);
    logic [63:0] row [0:MAX_BITS_LIMIT];
    logic [63:0] sum;
    int lim;
    sum = '0;
    lim = (j > i) ? i : j;
    for (int k = 0; k <= MAX_BITS_LIMIT; k++) begin
      row[k] = (k == 0) ? 64'd1 : 64'd0;
    end
    for (int r = 1; r <= i; r++) begin
      for (int k = MAX_BITS_LIMIT; k >= 1; k--) begin
        row[k] = row[k] + row[k-1];
      end
    end
    for (int k = 0; k <= lim; k++) begin
      sum = sum + row[k];
    end
    return sum;
  endfunction

endpackage

// ----- src/bwwu_count_rom.sv -----
// Read-only table of bounded-weight word counts with a registered read port.
module bwwu_count_rom #(
  parameter int MAX_BITS = bwwu_pkg::MAX_BITS_DEF
) (
  input  logic                              clk,
  input  logic [$clog2(MAX_BITS+1)-1:0]     row,
  input  logic [$clog2(MAX_BITS+1)-1:0]     col,
  output logic [MAX_BITS:0]                 data
);

  localparam int CW = MAX_BITS + 1;

  logic [CW-1:0] tab [0:MAX_BITS][0:MAX_BITS];

  for (genvar i = 0; i <= MAX_BITS; i++) begin : g_row
    for (genvar j = 0; j <= MAX_BITS; j++) begin : g_col
      localparam logic [63:0] ENTRY = bwwu_pkg::bounded_count(i, j);
      assign tab[i][j] = ENTRY[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    data <= tab[row][col];
  end

endmodule

// ----- src/bwwu_cmp_sub.sv -----
// Shared compare and subtract unit used for the range check and every bit step.
module bwwu_cmp_sub #(
  parameter int MAX_BITS = bwwu_pkg::MAX_BITS_DEF
) (
  input  logic [MAX_BITS:0]   a,
  input  logic [MAX_BITS:0]   b,
  output logic [MAX_BITS:0]   diff,
  output bwwu_pkg::cmp_sts_t  sts
);

  logic [MAX_BITS+1:0] wide;

  // The borrow out of the subtraction tells whether b exceeds a.
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[MAX_BITS:0];
  assign sts.gt = !wide[MAX_BITS+1] && (wide[MAX_BITS:0] != '0);
  assign sts.a_zero = (a == '0);

endmodule

// ----- src/bounded_weight_word_unrank_unit.sv -----
// Top level of the bounded-weight binary word unranker: sequencer, registers and datapath.
//
//   channel   signals                                  direction
//   item      item_valid, item_stall, rank             in  (item_stall driven here)
//   result    result_valid, result_stall, word,        out (result_stall driven outside)
//             in_range
//   cfg       cfg_valid, cfg_ready, cfg_index,         in  (cfg_ready driven here)
//             cfg_data
//
// After its transaction an item passes through ST_TOTAL, which checks the rank against
// the total count, then ST_SCAN, with one compare and subtract per bit position (word_bits
// saturated at MAX_BITS); an out-of-range rank skips the scan. A new item is taken
// only in ST_IDLE, after the result transaction of the last one completes.
// Reset is synchronous and active high; it returns both registers to 32 and the
// sequencer to idle. item_stall stays high from acceptance until the result
// transaction completes, and a stalled result holds its word and flag.
module bounded_weight_word_unrank_unit #(
  parameter int MAX_BITS = bwwu_pkg::MAX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [MAX_BITS:0]                 rank,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [MAX_BITS-1:0]               word,
  output logic                              in_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bwwu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwwu_pkg::CFG_W-1:0]        cfg_data
);

  localparam int IW = $clog2(MAX_BITS + 1);
  localparam int BW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int CW = MAX_BITS + 1;

  bwwu_pkg::state_t state, state_next;

  logic [bwwu_pkg::CFG_W-1:0] word_bits_r;
  logic [bwwu_pkg::CFG_W-1:0] max_ones_r;

  logic [CW-1:0]       rank_r, rank_next;
  logic [IW-1:0]       pos, pos_next;
  logic [IW-1:0]       ones, ones_next;
  logic [MAX_BITS-1:0] word_r, word_next;
  logic                in_range_r, in_range_next;

  logic [IW-1:0]       nb_lim;
  logic [IW-1:0]       ones_lim;
  logic [IW-1:0]       rom_row;
  logic [IW-1:0]       rom_col;
  logic [CW-1:0]       rom_data;
  logic [CW-1:0]       diff;
  bwwu_pkg::cmp_sts_t  sts;
  logic                take;
  logic                out_of_range;
  logic [IW-1:0]       ones_after;
  logic [IW-1:0]       pos_m1;
  logic [BW-1:0]       bit_idx;

  // The user must write configuration only while idle; it is not enforced, so always open.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits_r <= bwwu_pkg::WORD_BITS_RST;
      max_ones_r  <= bwwu_pkg::MAX_ONES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bwwu_pkg::REG_WORD_BITS: word_bits_r <= cfg_data;
        bwwu_pkg::REG_MAX_ONES:  max_ones_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Word length saturates at MAX_BITS, and the allowed ones at the word length.
  assign nb_lim = (word_bits_r > bwwu_pkg::CFG_W'(MAX_BITS)) ? IW'(MAX_BITS)
                                                            : IW'(word_bits_r);
  assign ones_lim = (max_ones_r > bwwu_pkg::CFG_W'(nb_lim)) ? nb_lim : IW'(max_ones_r);

  bwwu_count_rom #(.MAX_BITS(MAX_BITS)) u_rom (
    .clk  (clk),
    .row  (rom_row),
    .col  (rom_col),
    .data (rom_data)
  );

  bwwu_cmp_sub #(.MAX_BITS(MAX_BITS)) u_cmp (
    .a    (rank_r),
    .b    (rom_data),
    .diff (diff),
    .sts  (sts)
  );

  // A rank of zero or above the total count is out of range.
  assign out_of_range = sts.a_zero || sts.gt;

  // A bit is set when the remaining rank passes the count of the lower positions
  // and an allowed one is still left.
  assign take = sts.gt && (ones != '0);
  assign ones_after = take ? (ones - IW'(1)) : ones;
  assign pos_m1 = pos - IW'(1);
  assign bit_idx = BW'(pos_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwwu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rank_r     <= rank_next;
    pos        <= pos_next;
    ones       <= ones_next;
    word_r     <= word_next;
    in_range_r <= in_range_next;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bwwu_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = bwwu_pkg::ST_TOTAL;
        end
      end
      bwwu_pkg::ST_TOTAL: begin
        if (out_of_range || (pos == '0)) begin
          state_next = bwwu_pkg::ST_DONE;
        end else begin
          state_next = bwwu_pkg::ST_SCAN;
        end
      end
      bwwu_pkg::ST_SCAN: begin
        if (pos == IW'(1)) begin
          state_next = bwwu_pkg::ST_DONE;
        end
      end
      bwwu_pkg::ST_DONE: begin
        if (!result_stall) begin
          state_next = bwwu_pkg::ST_IDLE;
        end
      end
      default: state_next = bwwu_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs and the table address. The address for the next cycle's
  // count is formed here so that the table read lines up with the step that uses it.
  always_comb begin
    item_stall   = 1'b1;
    result_valid = 1'b0;
    rom_row      = '0;
    rom_col      = '0;
    case (state)
      bwwu_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        rom_row    = nb_lim;
        rom_col    = ones_lim;
      end
      bwwu_pkg::ST_TOTAL: begin
        rom_row = (pos != '0) ? pos_m1 : '0;
        rom_col = ones;
      end
      bwwu_pkg::ST_SCAN: begin
        rom_row = (pos > IW'(1)) ? (pos - IW'(2)) : '0;
        rom_col = ones_after;
      end
      bwwu_pkg::ST_DONE: begin
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath updates.
  always_comb begin
    rank_next     = rank_r;
    pos_next      = pos;
    ones_next     = ones;
    word_next     = word_r;
    in_range_next = in_range_r;
    case (state)
      bwwu_pkg::ST_IDLE: begin
        if (item_valid) begin
          rank_next     = rank;
          pos_next      = nb_lim;
          ones_next     = ones_lim;
          word_next     = '0;
          in_range_next = 1'b0;
        end
      end
      bwwu_pkg::ST_TOTAL: begin
        in_range_next = !out_of_range;
      end
      bwwu_pkg::ST_SCAN: begin
        if (take) begin
          rank_next          = diff;
          word_next[bit_idx] = 1'b1;
        end
        ones_next = ones_after;
        pos_next  = pos_m1;
      end
      default: ;
    endcase
  end

  assign word     = word_r;
  assign in_range = in_range_r;

endmodule
